/* src/tcpc_pkg.sv */
package tcpc_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int CELL_W     = COL_W + ROW_W;

  localparam logic [7:0]         SPACE_CHAR     = 8'h20;
  localparam logic signed [15:0] EMPTY_PRIORITY = -16'sd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_BLANK_ATTR    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        attr;
    logic [7:0]         code;
  } cell_t;

endpackage

/* src/text_cell_priority_compositor_core.sv */
// Character cell frame with a per-cell drawing priority.
// Items enter on the in_* channel and results leave on the out_* channel, both
// with valid and ready. Every item gives exactly one result, in order.
// The frame is one synchronous memory of 8192 words with a registered read.
// A draw or a read item issues its memory read when it is accepted; the
// S_LOOK state then compares and writes back, and the S_DONE state loads the
// output register once that register is free. The block works on one item
// at a time and accepts no new item until the last has reached the output
// register. A clear item walks the memory one word per cycle, then gives its
// result. After reset the same walk fills the frame with spaces, the zero
// attribute and priority -1; no item is accepted meanwhile, but register
// writes on the cfg_* port are taken at all times.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and is held once finished until the register frees.
module text_cell_priority_compositor_core
  import tcpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] x_start_i,
  input  logic signed [15:0] row_y_i,
  input  logic [15:0]        char_offset_i,
  input  logic [7:0]         char_code_i,
  input  logic [15:0]        color_attr_i,
  input  logic signed [15:0] priority_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               written_o,
  output logic [7:0]         cell_char_o,
  output logic [15:0]        cell_attr_o,
  output logic               in_bounds_o
);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [7:0]  width_q;
  logic [6:0]  height_q;
  logic [15:0] blank_q;
  logic [15:0] sweep_attr_q, sweep_attr_d;
  logic        clear_pend_q, clear_pend_d;
  logic [CELL_W-1:0] cnt_q, cnt_d;

  logic [1:0]         op_q;
  logic [CELL_W-1:0]  addr_q;
  logic               inb_q;
  logic [7:0]         code_q;
  logic [15:0]        attr_q;
  logic signed [15:0] prio_q;

  logic        res_wr_q, res_wr_d;
  logic [7:0]  res_code_q, res_code_d;
  logic [15:0] res_attr_q, res_attr_d;
  logic        res_inb_q, res_inb_d;

  logic        out_valid_q;
  logic        out_wr_q;
  logic [7:0]  out_code_q;
  logic [15:0] out_attr_q;
  logic        out_inb_q;
  logic        out_load;

  cell_t mem [CELL_COUNT];
  cell_t rd_q;
  cell_t wr_data;
  logic  mem_we;
  logic [CELL_W-1:0] wr_addr;
  logic [CELL_W-1:0] rd_addr;

  logic               in_fire;
  logic signed [17:0] col;
  logic [16:0]        w_lim;
  logic [14:0]        h_lim;
  logic               col_ok, row_ok;
  logic               draw_ok;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    w_lim = (17'(width_q) > 17'(MAX_COLS)) ? 17'(MAX_COLS) : 17'(width_q);
    h_lim = (15'(height_q) > 15'(MAX_ROWS)) ? 15'(MAX_ROWS) : 15'(height_q);
    if (op_i == OP_DRAW) begin
      col = {{2{x_start_i[15]}}, x_start_i} + {2'b00, char_offset_i};
    end else begin
      col = {{2{x_start_i[15]}}, x_start_i};
    end
    col_ok  = !col[17] && (col[16:0] < w_lim);
    row_ok  = !row_y_i[15] && (row_y_i[14:0] < h_lim);
    rd_addr = {row_y_i[ROW_W-1:0], col[COL_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd80;
      height_q <= 7'd25;
      blank_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[7:0];
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i[6:0];
        REG_BLANK_ATTR:    blank_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_i;
      addr_q <= rd_addr;
      inb_q  <= col_ok && row_ok;
      code_q <= char_code_i;
      attr_q <= color_attr_i;
      prio_q <= priority_req_i;
    end
    rd_q <= mem[rd_addr];
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign draw_ok = (op_q == OP_DRAW) && inb_q && !(rd_q.prio > prio_q);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sweep_attr_d = sweep_attr_q;
    clear_pend_d = clear_pend_q;
    res_wr_d     = res_wr_q;
    res_code_d   = res_code_q;
    res_attr_d   = res_attr_q;
    res_inb_d    = res_inb_q;
    mem_we       = 1'b0;
    wr_addr      = addr_q;
    wr_data      = '{prio: prio_q, attr: attr_q, code: code_q};
    case (state_q)
      S_SWEEP: begin
        mem_we  = 1'b1;
        wr_addr = cnt_q;
        wr_data = '{prio: EMPTY_PRIORITY, attr: sweep_attr_q, code: SPACE_CHAR};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CELL_W'(CELL_COUNT - 1)) begin
          clear_pend_d = 1'b0;
          state_d      = clear_pend_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (op_i == OP_CLEAR) begin
            sweep_attr_d = blank_q;
            clear_pend_d = 1'b1;
            cnt_d        = '0;
            res_wr_d     = 1'b0;
            res_code_d   = '0;
            res_attr_d   = '0;
            res_inb_d    = 1'b0;
            state_d      = S_SWEEP;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        mem_we     = draw_ok;
        res_wr_d   = draw_ok;
        res_inb_d  = inb_q && ((op_q == OP_DRAW) || (op_q == OP_READ));
        res_code_d = ((op_q == OP_READ) && inb_q) ? rd_q.code : 8'd0;
        res_attr_d = ((op_q == OP_READ) && inb_q) ? rd_q.attr : 16'd0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      cnt_q        <= '0;
      sweep_attr_q <= 16'd0;
      clear_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      sweep_attr_q <= sweep_attr_d;
      clear_pend_q <= clear_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_wr_q   <= res_wr_d;
    res_code_q <= res_code_d;
    res_attr_q <= res_attr_d;
    res_inb_q  <= res_inb_d;
    if (out_load) begin
      out_wr_q   <= res_wr_q;
      out_code_q <= res_code_q;
      out_attr_q <= res_attr_q;
      out_inb_q  <= res_inb_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign written_o   = out_wr_q;
  assign cell_char_o = out_code_q;
  assign cell_attr_o = out_attr_q;
  assign in_bounds_o = out_inb_q;

  a_written_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && written_o) |-> in_bounds_o)
    else $error("written result for an off-screen cell");

  a_offscreen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_bounds_o) |-> (cell_char_o == 8'd0 && cell_attr_o == 16'd0))
    else $error("off-screen result carries cell data");

  a_write_only_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && mem_we) |-> (op_q == OP_DRAW && inb_q))
    else $error("cell written by an item that is not an on-screen draw");

  a_no_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == OP_CLEAR) |=> (state_q == S_SWEEP && !in_ready_o))
    else $error("clear did not start the frame walk");

endmodule

/* verif/tb_text_cell_priority_compositor_core.sv */
`timescale 1ns / 100ps

module tb_text_cell_priority_compositor_core;
  import tcpc_pkg::*;

  localparam int STALL_LIMIT = 50000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        off;
    logic [7:0]         code;
    logic [15:0]        attr;
    logic signed [15:0] prio;
  } glyph_item_t;

  typedef struct packed {
    logic        written;
    logic [7:0]  code;
    logic [15:0] attr;
    logic        in_bounds;
  } cell_reply_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_idx_i      = 2'd0;
  logic [15:0]        cfg_data_i     = 16'd0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i           = 2'd0;
  logic signed [15:0] x_start_i      = 16'sd0;
  logic signed [15:0] row_y_i        = 16'sd0;
  logic [15:0]        char_offset_i  = 16'd0;
  logic [7:0]         char_code_i    = 8'd0;
  logic [15:0]        color_attr_i   = 16'd0;
  logic signed [15:0] priority_req_i = 16'sd0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               written_o;
  logic [7:0]         cell_char_o;
  logic [15:0]        cell_attr_o;
  logic               in_bounds_o;

  text_cell_priority_compositor_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .x_start_i     (x_start_i),
    .row_y_i       (row_y_i),
    .char_offset_i (char_offset_i),
    .char_code_i   (char_code_i),
    .color_attr_i  (color_attr_i),
    .priority_req_i(priority_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .written_o     (written_o),
    .cell_char_o   (cell_char_o),
    .cell_attr_o   (cell_attr_o),
    .in_bounds_o   (in_bounds_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the frame and of the screen registers.
  logic [7:0]         frame_code [CELL_COUNT];
  logic [15:0]        frame_attr [CELL_COUNT];
  logic signed [15:0] frame_prio [CELL_COUNT];
  logic [7:0]         scr_width  = 8'd80;
  logic [6:0]         scr_height = 7'd25;
  logic [15:0]        blank_attr = 16'd0;

  glyph_item_t glyph_q[$];
  cell_reply_t reply_q[$];
  glyph_item_t send_item;
  glyph_item_t taken_item;
  cell_reply_t taken_reply;
  cell_reply_t got_reply;

  int  items_queued   = 0;
  int  results_seen   = 0;
  int  errors         = 0;
  int  stall_cycles   = 0;
  int  drawn_count    = 0;
  int  lost_count     = 0;
  int  visible_reads  = 0;
  int  clear_count    = 0;
  int  setting_count  = 1;
  int  send_gap       = 0;
  int  sink_gap       = 0;
  int  hold_left      = 0;
  int  holds_asked    = 0;
  int  holds_served   = 0;
  bit  calm_tail      = 1'b0;
  logic in_took;

  function automatic void blank_frame();
    for (int i = 0; i < CELL_COUNT; i++) begin
      frame_code[i] = SPACE_CHAR;
      frame_attr[i] = blank_attr;
      frame_prio[i] = EMPTY_PRIORITY;
    end
  endfunction

  function automatic bit cell_index(input int col, input int row, output int idx);
    int w;
    int h;
    w   = (int'(scr_width) > MAX_COLS) ? MAX_COLS : int'(scr_width);
    h   = (int'(scr_height) > MAX_ROWS) ? MAX_ROWS : int'(scr_height);
    idx = 0;
    if (col < 0 || col >= w || row < 0 || row >= h) return 1'b0;
    idx = row * MAX_COLS + col;
    return 1'b1;
  endfunction

  function automatic cell_reply_t composite(input glyph_item_t it);
    cell_reply_t r;
    int          idx;
    r = '0;
    case (it.op)
      OP_CLEAR: begin
        blank_frame();
        clear_count++;
      end
      OP_DRAW: begin
        if (cell_index(int'($signed(it.x)) + int'(it.off), int'($signed(it.y)), idx)) begin
          r.in_bounds = 1'b1;
          if (!($signed(frame_prio[idx]) > $signed(it.prio))) begin
            frame_code[idx] = it.code;
            frame_attr[idx] = it.attr;
            frame_prio[idx] = it.prio;
            r.written       = 1'b1;
            drawn_count++;
          end else begin
            lost_count++;
          end
        end
      end
      OP_READ: begin
        if (cell_index(int'($signed(it.x)), int'($signed(it.y)), idx)) begin
          r.code      = frame_code[idx];
          r.attr      = frame_attr[idx];
          r.in_bounds = 1'b1;
          visible_reads++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_reply(input cell_reply_t got);
    cell_reply_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: result with none expected: written %0d char %h attr %h in_bounds %0d",
               $time, got.written, got.code, got.attr, got.in_bounds);
      errors++;
    end else begin
      want = reply_q.pop_front();
      if (got.written !== want.written) begin
        $display("%0t: written expected %0d actual %0d", $time, want.written, got.written);
        errors++;
      end
      if (got.code !== want.code) begin
        $display("%0t: cell_char expected %h actual %h", $time, want.code, got.code);
        errors++;
      end
      if (got.attr !== want.attr) begin
        $display("%0t: cell_attr expected %h actual %h", $time, want.attr, got.attr);
        errors++;
      end
      if (got.in_bounds !== want.in_bounds) begin
        $display("%0t: in_bounds expected %0d actual %0d", $time, want.in_bounds,
                 got.in_bounds);
        errors++;
      end
    end
  endtask

  // Driver: the payload changes only while valid is low or on the falling edge after an item was taken.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (glyph_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else begin
        send_item = glyph_q.pop_front();
        op_i           <= send_item.op;
        x_start_i      <= send_item.x;
        row_y_i        <= send_item.y;
        char_offset_i  <= send_item.off;
        char_code_i    <= send_item.code;
        color_attr_i   <= send_item.attr;
        priority_req_i <= send_item.prio;
        in_valid_i     <= 1'b1;
      end
    end
  end

  // Receiver with random stalls and an occasional long hold-off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
      stall_cycles = 0;
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        taken_item.op   = op_e'(op_i);
        taken_item.x    = x_start_i;
        taken_item.y    = row_y_i;
        taken_item.off  = char_offset_i;
        taken_item.code = char_code_i;
        taken_item.attr = color_attr_i;
        taken_item.prio = priority_req_i;
        taken_reply     = composite(taken_item);
        reply_q.push_back(taken_reply);
      end
      if (out_valid_o && out_ready_i) begin
        got_reply.written   = written_o;
        got_reply.code      = cell_char_o;
        got_reply.attr      = cell_attr_o;
        got_reply.in_bounds = in_bounds_o;
        check_reply(got_reply);
        results_seen++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  task automatic push_item(input op_e op, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] off, input logic [7:0] code,
                           input logic [15:0] attr, input logic [15:0] prio);
    glyph_item_t it;
    it.op   = op;
    it.x    = x;
    it.y    = y;
    it.off  = off;
    it.code = code;
    it.attr = attr;
    it.prio = prio;
    glyph_q.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_SCREEN_WIDTH:  scr_width  = data[7:0];
      REG_SCREEN_HEIGHT: scr_height = data[6:0];
      REG_BLANK_ATTR:    blank_attr = data;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_screen(input logic [7:0] w, input logic [6:0] h, input logic [15:0] a);
    write_reg(REG_SCREEN_WIDTH, {8'($urandom), w});
    write_reg(REG_SCREEN_HEIGHT, {9'($urandom), h});
    write_reg(REG_BLANK_ATTR, a);
    setting_count++;
  endtask

  function automatic logic [15:0] pick_prio();
    if ($urandom_range(0, 9) < 7) return 16'(int'($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  // Mostly text runs and reads around the screen edges, some raw noise and rare clears.
  task automatic random_items(input int count);
    int          w;
    int          h;
    int          made;
    int          kind;
    int          run_len;
    int          x;
    int          y;
    logic [15:0] prio;
    w    = (int'(scr_width) > MAX_COLS) ? MAX_COLS : int'(scr_width);
    h    = (int'(scr_height) > MAX_ROWS) ? MAX_ROWS : int'(scr_height);
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 199);
      if (kind == 0) begin
        push_item(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom));
        made++;
      end else if (kind < 18) begin
        push_item(op_e'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        made++;
      end else if (kind < 110) begin
        run_len = $urandom_range(1, 8);
        x       = int'($urandom_range(0, w + 10)) - 8;
        y       = int'($urandom_range(0, h + 4)) - 2;
        prio    = pick_prio();
        for (int k = 0; k < run_len; k++) begin
          push_item(OP_DRAW, 16'(x), 16'(y), 16'(k), 8'($urandom), 16'($urandom), prio);
        end
        made += run_len;
      end else begin
        x = int'($urandom_range(0, w + 6)) - 3;
        y = int'($urandom_range(0, h + 4)) - 2;
        push_item(OP_READ, 16'(x), 16'(y), 16'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom));
        made++;
      end
    end
  endtask

  task automatic screen_phase(input logic [7:0] w, input logic [6:0] h, input logic [15:0] a,
                              input int count);
    wait_drained();
    set_screen(w, h, a);
    push_item(OP_CLEAR, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    random_items(count);
  endtask

  initial begin
    blank_frame();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_item(OP_READ, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd79, 16'd24, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd80, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd0, 16'd25, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'hFFFF, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd0, 16'h8000, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_DRAW, 16'd0, 16'd0, 16'd0, 8'h41, 16'hFFFF, 16'h8000);
    push_item(OP_DRAW, 16'd0, 16'd0, 16'd0, 8'h42, 16'h1234, 16'hFFFF);
    push_item(OP_DRAW, 16'd70, 16'd24, 16'd9, 8'hFF, 16'hABCD, 16'h7FFF);
    push_item(OP_DRAW, 16'd70, 16'd24, 16'd9, 8'h00, 16'h0001, 16'h7FFE);
    push_item(OP_DRAW, 16'hFFFB, 16'd3, 16'd5, 8'h7E, 16'h5A5A, 16'd0);
    push_item(OP_DRAW, 16'h7FFF, 16'd0, 16'h8002, 8'h21, 16'h0F0F, 16'h7FFF);
    push_item(OP_DRAW, 16'h8000, 16'd2, 16'h8000, 8'h23, 16'hA5A5, 16'd5);
    push_item(OP_DRAW, 16'd0, 16'd0, 16'hFFFF, 8'h24, 16'h0000, 16'h7FFF);
    push_item(OP_DRAW, 16'd10, 16'hFFFF, 16'd0, 8'h25, 16'h1111, 16'h7FFF);
    push_item(OP_DRAW, 16'd10, 16'd25, 16'd0, 8'h26, 16'h2222, 16'h7FFF);
    push_item(OP_READ, 16'd79, 16'd24, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd0, 16'd3, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd0, 16'd2, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    push_item(OP_CLEAR, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
    push_item(OP_READ, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);

    screen_phase(8'd128, 7'd64, 16'($urandom), 160);
    holds_asked++;
    screen_phase(8'd255, 7'd127, 16'($urandom), 160);
    screen_phase(8'd1, 7'd1, 16'hFFFF, 120);
    screen_phase(8'd0, 7'd0, 16'h0000, 100);
    screen_phase(8'd200, 7'd3, 16'($urandom), 160);
    wait_drained();
    calm_tail = 1'b1;
    screen_phase(8'd80, 7'd25, 16'($urandom), 200);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, reply_q.size());
      errors++;
    end
    $display("Checked %0d results across %0d screen settings, including a long output stall.",
             results_seen, setting_count);
    $display("Cells drawn %0d, draws lost on priority %0d, on-screen reads %0d, clears %0d.",
             drawn_count, lost_count, visible_reads, clear_count);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
